FILE: hw/rtl/vdw_pkg.sv
// ----------------------------------------------------------------------------
// vdw_pkg
// shared types and constants for the vertex dedup window
// ----------------------------------------------------------------------------
package vdw_pkg;

  localparam int COORD_W     = 24;
  localparam int IDX_W       = 24;
  localparam int DIST_W      = 50;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int SEARCH_BACK_DEF = 128;

  localparam logic [IDX_W-1:0] COUNT_MAX = {IDX_W{1'b1}};

  localparam logic [1:0] MODE_VERTEX     = 2'd0;
  localparam logic [1:0] MODE_VERTEX_TEX = 2'd1;
  localparam logic [1:0] MODE_NORMAL     = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] main_index;
    logic [IDX_W-1:0] tex_index;
    logic             new_main;
    logic             new_tex;
    logic             overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  // push: new entry enters at the head; rot: ring turns one place towards the head
  typedef struct packed {
    logic push;
    logic rot;
  } chain_ctl_t;

endpackage

FILE: hw/rtl/vdw_cell.sv
// ----------------------------------------------------------------------------
// vdw_cell
// one stored entry of a ring; takes its left or right neighbour's value
// ----------------------------------------------------------------------------
module vdw_cell import vdw_pkg::*; #(
  parameter int DW = 3 * COORD_W
) (
  input  logic          clk,
  input  chain_ctl_t    ctl,
  input  logic [DW-1:0] left_d,
  input  logic [DW-1:0] right_d,
  output logic [DW-1:0] q
);

  logic [DW-1:0] q_r;
  logic [DW-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.push) begin
      q_nxt = left_d;
    end else if (ctl.rot) begin
      q_nxt = right_d;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: hw/rtl/vdw_chain.sv
// ----------------------------------------------------------------------------
// vdw_chain
// row of cells holding the newest entries of one store, newest at the head
// ----------------------------------------------------------------------------
module vdw_chain import vdw_pkg::*; #(
  parameter int DW    = 3 * COORD_W,
  parameter int DEPTH = SEARCH_BACK_DEF + 1
) (
  input  logic          clk,
  input  chain_ctl_t    ctl,
  input  logic [DW-1:0] new_d,
  output logic [DW-1:0] head
);

  logic [DW-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] l_d;
    logic [DW-1:0] r_d;
    if (i == 0) begin : g_first
      assign l_d = new_d;
    end else begin : g_mid_l
      assign l_d = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_d = q[0];
    end else begin : g_mid_r
      assign r_d = q[i+1];
    end
    vdw_cell #(.DW(DW)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_d  (l_d),
      .right_d (r_d),
      .q       (q[i])
    );
  end

  assign head = q[0];

endmodule

FILE: hw/rtl/vdw_dist.sv
// ----------------------------------------------------------------------------
// vdw_dist
// squared distance against threshold; squares registered, then sum and compare
// ----------------------------------------------------------------------------
module vdw_dist import vdw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  vec_t              a,
  input  vec_t              b,
  input  logic [DIST_W-1:0] thr,
  output logic              hit
);

  logic [SQ_W-1:0] sx_r, sy_r, sz_r;
  logic            v_r;
  logic [COORD_W-1:0] ax, ay, az;
  logic [DIST_W-1:0]  sum;

  function automatic logic [COORD_W-1:0] absdiff(logic signed [COORD_W-1:0] p,
                                                 logic signed [COORD_W-1:0] q);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        m;
    d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

  assign ax = absdiff(a.x, b.x);
  assign ay = absdiff(a.y, b.y);
  assign az = absdiff(a.z, b.z);

  always_ff @(posedge clk) begin
    sx_r <= ax * ax;
    sy_r <= ay * ay;
    sz_r <= az * az;
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  assign sum = DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
  assign hit = v_r && (sum < thr);

endmodule

FILE: hw/rtl/vertex_dedup_window.sv
// ----------------------------------------------------------------------------
// vertex_dedup_window
// tolerance based dedup of positions, texture coordinates and normals
// ----------------------------------------------------------------------------
// Each store keeps its newest SEARCH_BACK+1 entries in a row of cells, newest
// at the head. A search turns the selected ring once round, one cell per cycle,
// past a single distance unit whose squares are registered; a drain and a
// decide state follow before the result is ready. When mode 1 finds its
// position, it goes on to search the texture ring. Only one item is in
// flight; a finished result waits in the output register while the next
// item is taken. The threshold register is written when the block is idle.
module vertex_dedup_window import vdw_pkg::*; #(
  parameter int SEARCH_BACK = SEARCH_BACK_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIST_W-1:0] cfg_data
);

  localparam int DEPTH = SEARCH_BACK + 1;
  localparam int KW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(DEPTH - 1);

  typedef enum logic [2:0] {S_IDLE, S_SRCH, S_DRAIN, S_DECIDE, S_DONE} state_t;
  typedef enum logic [1:0] {SEL_POS, SEL_TEX, SEL_NRM} sel_t;

  state_t            state_r, state_nxt;
  sel_t              sel_r, sel_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [KW-1:0]     k1_r;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  fidx_r, fidx_nxt;
  logic [IDX_W-1:0]  pos_cnt_r, pos_cnt_nxt;
  logic [IDX_W-1:0]  tex_cnt_r, tex_cnt_nxt;
  logic [IDX_W-1:0]  nrm_cnt_r, nrm_cnt_nxt;
  logic [DIST_W-1:0] thr_r;
  in_item_t          item_r;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;

  chain_ctl_t         pos_ctl, tex_ctl, nrm_ctl;
  logic [3*COORD_W-1:0] pos_head, nrm_head, pos_new;
  logic [2*COORD_W-1:0] tex_head, tex_new;
  vec_t               qv, hv, tv;
  logic [IDX_W-1:0]   cnt_sel;
  logic               issue_v, hit;

  // storage rings
  assign pos_new = {item_r.coord_x, item_r.coord_y, item_r.coord_z};
  assign tex_new = {item_r.tex_u, item_r.tex_v};

  vdw_chain #(.DW(3*COORD_W), .DEPTH(DEPTH)) u_pos (
    .clk(clk), .ctl(pos_ctl), .new_d(pos_new), .head(pos_head)
  );
  vdw_chain #(.DW(2*COORD_W), .DEPTH(DEPTH)) u_tex (
    .clk(clk), .ctl(tex_ctl), .new_d(tex_new), .head(tex_head)
  );
  vdw_chain #(.DW(3*COORD_W), .DEPTH(DEPTH)) u_nrm (
    .clk(clk), .ctl(nrm_ctl), .new_d(pos_new), .head(nrm_head)
  );

  // query and head of the ring being searched; texture z is taken as zero
  assign tv = '{x: tex_head[2*COORD_W-1:COORD_W], y: tex_head[COORD_W-1:0], z: '0};

  always_comb begin
    case (sel_r)
      SEL_TEX: begin
        qv      = '{x: item_r.tex_u, y: item_r.tex_v, z: '0};
        hv      = tv;
        cnt_sel = tex_cnt_r;
      end
      SEL_NRM: begin
        qv      = '{x: item_r.coord_x, y: item_r.coord_y, z: item_r.coord_z};
        hv      = nrm_head;
        cnt_sel = nrm_cnt_r;
      end
      default: begin
        qv      = '{x: item_r.coord_x, y: item_r.coord_y, z: item_r.coord_z};
        hv      = pos_head;
        cnt_sel = pos_cnt_r;
      end
    endcase
  end

  // only written entries take part
  assign issue_v = (state_r == S_SRCH) && ({{(IDX_W-KW){1'b0}}, k_r} < cnt_sel);

  vdw_dist u_dist (
    .clk(clk), .rst_n(rst_n), .in_v(issue_v), .a(qv), .b(hv), .thr(thr_r), .hit(hit)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    k_nxt       = k_r;
    found_nxt   = found_r;
    fidx_nxt    = fidx_r;
    pos_cnt_nxt = pos_cnt_r;
    tex_cnt_nxt = tex_cnt_r;
    nrm_cnt_nxt = nrm_cnt_r;
    res_nxt     = res_r;
    pos_ctl     = '0;
    tex_ctl     = '0;
    nrm_ctl     = '0;

    // first hit is the newest match
    if (hit && !found_r) begin
      found_nxt = 1'b1;
      fidx_nxt  = cnt_sel - {{(IDX_W-KW){1'b0}}, k1_r};
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          k_nxt     = '0;
          found_nxt = 1'b0;
          if (in_data.mode == MODE_NORMAL) begin
            sel_nxt   = SEL_NRM;
            state_nxt = S_SRCH;
          end else if (in_data.mode == MODE_VERTEX ||
                       in_data.mode == MODE_VERTEX_TEX) begin
            sel_nxt   = SEL_POS;
            state_nxt = S_SRCH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SRCH: begin
        case (sel_r)
          SEL_TEX: tex_ctl.rot = 1'b1;
          SEL_NRM: nrm_ctl.rot = 1'b1;
          default: pos_ctl.rot = 1'b1;
        endcase
        k_nxt = k_r + 1'b1;
        if (k_r == K_LAST) begin
          k_nxt     = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        case (sel_r)
          SEL_POS: begin
            if (found_r) begin
              res_nxt.main_index = fidx_r;
              if (item_r.mode == MODE_VERTEX_TEX) begin
                sel_nxt   = SEL_TEX;
                k_nxt     = '0;
                found_nxt = 1'b0;
                state_nxt = S_SRCH;
              end
            end else if (pos_cnt_r == COUNT_MAX || tex_cnt_r == COUNT_MAX) begin
              res_nxt.overflow = 1'b1;
            end else begin
              pos_ctl.push       = 1'b1;
              tex_ctl.push       = 1'b1;
              pos_cnt_nxt        = pos_cnt_r + 1'b1;
              tex_cnt_nxt        = tex_cnt_r + 1'b1;
              res_nxt.main_index = pos_cnt_r + 1'b1;
              res_nxt.tex_index  = tex_cnt_r + 1'b1;
              res_nxt.new_main   = 1'b1;
              res_nxt.new_tex    = 1'b1;
            end
          end
          SEL_TEX: begin
            if (found_r) begin
              res_nxt.tex_index = fidx_r;
            end else if (tex_cnt_r == COUNT_MAX) begin
              res_nxt.overflow = 1'b1;
            end else begin
              tex_ctl.push      = 1'b1;
              tex_cnt_nxt       = tex_cnt_r + 1'b1;
              res_nxt.tex_index = tex_cnt_r + 1'b1;
              res_nxt.new_tex   = 1'b1;
            end
          end
          default: begin
            if (found_r) begin
              res_nxt.main_index = fidx_r;
            end else if (nrm_cnt_r == COUNT_MAX) begin
              res_nxt.overflow = 1'b1;
            end else begin
              nrm_ctl.push       = 1'b1;
              nrm_cnt_nxt        = nrm_cnt_r + 1'b1;
              res_nxt.main_index = nrm_cnt_r + 1'b1;
              res_nxt.new_main   = 1'b1;
            end
          end
        endcase
      end
      S_DONE: begin
        // result moves to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    fidx_r <= fidx_nxt;
    k1_r   <= k_r;
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r <= res_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_POS;
      k_r         <= '0;
      found_r     <= 1'b0;
      pos_cnt_r   <= '0;
      tex_cnt_r   <= '0;
      nrm_cnt_r   <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sel_r     <= sel_nxt;
      k_r       <= k_nxt;
      found_r   <= found_nxt;
      pos_cnt_r <= pos_cnt_nxt;
      tex_cnt_r <= tex_cnt_nxt;
      nrm_cnt_r <= nrm_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/vdw_checker.sv
// ----------------------------------------------------------------------------
// vdw_checker
// port level checks for the vertex dedup window
// ----------------------------------------------------------------------------
module vdw_checker import vdw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time: a transfer is followed by a busy cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // an append never comes with overflow
  a_new_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.new_main || out_data.new_tex) |-> !out_data.overflow)
    else $error("append flagged as overflow");

  // an appended texture has a real index
  a_tex_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_tex |-> out_data.tex_index != '0)
    else $error("new texture without index");

endmodule

bind vertex_dedup_window vdw_checker u_vdw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
